// ===== hdl/bovl_pkg.sv =====
// shared types and constants for the bounded ordered value list
package bovl_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int TOTAL_W = 5;

   typedef enum logic [1:0] {
      ACT_HEAD   = 2'd0,
      ACT_TAIL   = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_DELETE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_APPLY = 1'b1
   } state_type;

   typedef logic signed [VALUE_W-1:0] value_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic       cmp_en;
      logic       apply;
      action_type action;
   } cell_ctl_type;

endpackage

// ===== hdl/bovl_cell.sv =====
// one list position: holds an entry, compares it and shifts it to or from its neighbours
module bovl_cell (
   input  logic                   clock,
   input  bovl_pkg::cell_ctl_type ctl,
   input  bovl_pkg::value_type    key,
   input  logic                   occupied,
   input  logic                   tail_here,
   input  bovl_pkg::value_type    left_value,
   input  bovl_pkg::value_type    right_value,
   input  logic                   seen_in,
   output bovl_pkg::value_type    value,
   output logic                   seen_out
);
   import bovl_pkg::*;

   value_type value_ff, value_in;
   logic      hit_ff, hit_in;
   logic      take_right;

   // on delete a match here or in a lower cell makes this cell take the entry to its right
   assign take_right = seen_in | hit_ff;
   assign seen_out   = take_right;
   assign value      = value_ff;

   always_comb begin
      hit_in = hit_ff;
      if (ctl.cmp_en) begin
         hit_in = occupied && (value_ff == key);
      end
   end

   always_comb begin
      value_in = value_ff;
      if (ctl.apply) begin
         unique case (ctl.action)
            ACT_HEAD: begin
               value_in = left_value;
            end
            ACT_TAIL: begin
               if (tail_here) begin
                  value_in = key;
               end
            end
            ACT_DELETE: begin
               if (take_right) begin
                  value_in = right_value;
               end
            end
            default: begin
               value_in = value_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
   end

endmodule

// ===== hdl/bovl_ctrl.sv =====
// sequencer, entry count and result register of the list
module bovl_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [1:0]                      rsp_status,
   output logic [4:0]                      rsp_entry_total,
   input  logic                            any_hit,
   output logic [bovl_pkg::CNT_W-1:0]      count,
   output logic                            key_from_req,
   output bovl_pkg::cell_ctl_type          ctl
);
   import bovl_pkg::*;

   state_type  state_ff, state_in;
   action_type action_ff, action_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       found_ff, found_in;
   status_type status_ff, status_in;
   logic       out_free, step, full, is_insert, apply;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign is_insert = (action_ff == ACT_HEAD) || (action_ff == ACT_TAIL);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready    = 1'b0;
      key_from_req = 1'b0;
      step         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            key_from_req = 1'b1;
         end
         S_APPLY: begin
            step = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      action_in = action_ff;
      if (req_valid && req_ready) begin
         action_in = action_type'(req_action);
      end
   end

   always_comb begin
      count_in  = count_ff;
      found_in  = found_ff;
      status_in = status_ff;
      apply     = 1'b0;
      if (step) begin
         found_in  = 1'b0;
         status_in = STAT_OK;
         unique case (action_ff)
            ACT_HEAD, ACT_TAIL: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  apply    = 1'b1;
               end
            end
            ACT_SEARCH: begin
               found_in = any_hit;
               if (!any_hit) begin
                  status_in = STAT_NOT_FOUND;
               end
            end
            ACT_DELETE: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else if (any_hit) begin
                  count_in = count_ff - 1'b1;
                  found_in = 1'b1;
                  apply    = 1'b1;
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   assign ctl.cmp_en = req_valid && req_ready;
   assign ctl.apply  = apply;
   assign ctl.action = action_ff;

   assign count           = count_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_total = TOTAL_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (step && is_insert && !full) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not grow the list");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STAT_FULL || status_ff == STAT_EMPTY)) |-> !found_ff)
      else $error("full or empty result flagged as found");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_APPLY))
      else $error("item applied while result still held");

endmodule

// ===== hdl/bounded_ordered_value_list_core.sv =====
// top level: row of list cells under one sequencer
//
//  channel | ports                                   | direction
//  req     | req_valid req_ready req_action req_value | in
//  rsp     | rsp_valid rsp_ready rsp_found rsp_status | out
//          | rsp_entry_total                          |
//
// an item is handled as a compare, in which every cell compares its entry with the
// value, then an update, in which the cells shift or load and the result register is written
// the update waits while an earlier result is still held on rsp
// reset clears the sequencer, the entry count and rsp_valid; entries are not cleared
// req_ready is high whenever the sequencer is idle, also while a result is held
module bounded_ordered_value_list_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_entry_total
);
   import bovl_pkg::*;

   cell_ctl_type     ctl;
   logic [CNT_W-1:0] count;
   logic             key_from_req;
   value_type        key_ff, key_in, key;
   value_type        cell_value [DEPTH];
   logic [DEPTH:0]   seen;

   always_comb begin
      key_in = key_ff;
      if (req_valid && req_ready) begin
         key_in = req_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // compare uses the incoming value, the update the one held
   assign key     = key_from_req ? req_value : key_ff;
   assign seen[0] = 1'b0;

   bovl_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status),
      .rsp_entry_total (rsp_entry_total),
      .any_hit         (seen[DEPTH]),
      .count           (count),
      .key_from_req    (key_from_req),
      .ctl             (ctl)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type left_value, right_value;

      if (i == 0) begin : g_head
         assign left_value = key_ff;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      bovl_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .key         (key),
         .occupied    (count > CNT_W'(i)),
         .tail_here   (count == CNT_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .seen_in     (seen[i]),
         .value       (cell_value[i]),
         .seen_out    (seen[i+1])
      );
   end

endmodule
